@@ hdl/integer_literal_parser_macros.svh @@
// ----------------------------------------------------------------------------
// integer_literal_parser_macros
// Assertion macros shared by the integer literal parser modules.
// ----------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_PARSER_MACROS_SVH
`define INTEGER_LITERAL_PARSER_MACROS_SVH

// same-cycle implication
`define ILP_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("integer literal parser: assertion failed");

// next-cycle implication
`define ILP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("integer literal parser: assertion failed");

`endif

@@ hdl/ilp_pkg.sv @@
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, character codes, and the digit weight and radix base functions of the parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CASE_BIT      = 8'h20;

    localparam int         VALUE_W      = 63;
    localparam int         WEIGHT_W     = 6;
    localparam int         BASE_W       = 5;
    localparam logic [5:0] WEIGHT_NONE  = 6'h3F;
    localparam logic [5:0] LETTER_BIAS  = 6'd10;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [4:0] BASE_BIN = 5'd2;
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_OCT = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic                last;
        logic                take;
        logic                lone_zero;
        radix_t              radix;
        logic [WEIGHT_W-1:0] weight;
    } token_t;

    function automatic logic [WEIGHT_W-1:0] char_weight(input logic [7:0] c);
        logic [7:0] w;
        w = {2'b00, WEIGHT_NONE};
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            w = c - CH_ZERO;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            w = c - CH_LOWER_A + {2'b00, LETTER_BIAS};
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            w = c - CH_UPPER_A + {2'b00, LETTER_BIAS};
        end
        return w[WEIGHT_W-1:0];
    endfunction

    function automatic logic [BASE_W-1:0] radix_base(input radix_t r);
        logic [BASE_W-1:0] b;
        unique case (r)
            RX_BIN:  b = BASE_BIN;
            RX_OCT:  b = BASE_OCT;
            RX_HEX:  b = BASE_HEX;
            default: b = BASE_DEC;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/ilp_char_if.sv @@
// ----------------------------------------------------------------------------
// ilp_char_if
// Character channel: one literal character and its last flag per beat.
// ----------------------------------------------------------------------------
interface ilp_char_if;

    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);

endinterface

@@ hdl/ilp_result_if.sv @@
// ----------------------------------------------------------------------------
// ilp_result_if
// Result channel: parsed value and status per beat.
// ----------------------------------------------------------------------------
interface ilp_result_if;

    logic        valid;
    logic        ready;
    logic [62:0] literal_value;
    logic [1:0]  status;

    modport source (output valid, output literal_value, output status, input ready);
    modport sink   (input valid, input literal_value, input status, output ready);

endinterface

@@ hdl/integer_literal_parser.sv @@
// ----------------------------------------------------------------------------
// integer_literal_parser
// Integer literal parser: prefix and radix selection, digit accumulation,
// saturation on overflow.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  chars    in   char_code[7:0], last_char
//  results  out  literal_value[62:0], status[1:0]
//
//  One character beat per cycle while the queue has room; a literal's
//  last character goes from classifier to queue, then from accumulator
//  to result register. The accumulate is a shift-add by the radix plus
//  one wide add and overflow check per cycle while tokens pop. Reset
//  clears the prefix state, queue and accumulator. A stalled result holds
//  only tokens that end a literal; the queue absorbs characters meanwhile.
// ----------------------------------------------------------------------------
module integer_literal_parser
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    ilp_char_if.sink     chars,
    ilp_result_if.source results
);

    logic            push;
    logic            push_ready;
    ilp_pkg::token_t push_tok;
    logic            pop;
    logic            pop_valid;
    ilp_pkg::token_t pop_tok;

    ilp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .push       (push),
        .push_tok   (push_tok),
        .push_ready (push_ready)
    );

    ilp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_tok   (push_tok),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_tok    (pop_tok),
        .pop_valid  (pop_valid)
    );

    ilp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok        (pop_tok),
        .tok_valid  (pop_valid),
        .pop        (pop),
        .results    (results)
    );

endmodule

@@ hdl/ilp_front.sv @@
// ----------------------------------------------------------------------------
// ilp_front
// Prefix tracking and character classification into digit tokens.
// ----------------------------------------------------------------------------
module ilp_front
(
    input  logic            clk,
    input  logic            rst_n,
    ilp_char_if.sink        chars,
    output logic            push,
    output ilp_pkg::token_t push_tok,
    input  logic            push_ready
);

    ilp_pkg::phase_t phase_reg;
    ilp_pkg::phase_t phase_next;
    ilp_pkg::radix_t radix_reg;
    ilp_pkg::radix_t radix_next;

    logic       is_us;
    logic       is_zero;
    logic [7:0] folded;
    logic       is_pfx;
    ilp_pkg::radix_t pfx_radix;

    assign is_us   = (chars.char_code == ilp_pkg::CH_UNDERSCORE);
    assign is_zero = (chars.char_code == ilp_pkg::CH_ZERO);
    assign folded  = chars.char_code | ilp_pkg::CASE_BIT;

    always_comb
    begin
        is_pfx    = 1'b1;
        pfx_radix = ilp_pkg::RX_OCT;
        unique case (folded)
            ilp_pkg::CH_LOWER_B: pfx_radix = ilp_pkg::RX_BIN;
            ilp_pkg::CH_LOWER_O: pfx_radix = ilp_pkg::RX_OCT;
            ilp_pkg::CH_LOWER_X: pfx_radix = ilp_pkg::RX_HEX;
            default:             is_pfx    = 1'b0;
        endcase
    end

    assign chars.ready = push_ready;
    assign push        = chars.valid && push_ready;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        if (!is_us)
        begin
            unique case (phase_reg)
                ilp_pkg::PH_IDLE:
                begin
                    radix_next = ilp_pkg::RX_DEC;
                    phase_next = is_zero ? ilp_pkg::PH_ZERO : ilp_pkg::PH_DIGITS;
                end
                ilp_pkg::PH_ZERO:
                begin
                    radix_next = pfx_radix;
                    phase_next = ilp_pkg::PH_DIGITS;
                end
                default:
                begin
                    phase_next = ilp_pkg::PH_DIGITS;
                end
            endcase
        end
        if (chars.last_char)
        begin
            phase_next = ilp_pkg::PH_IDLE;
            radix_next = ilp_pkg::RX_DEC;
        end
    end

    // token
    always_comb
    begin
        push_tok.last      = chars.last_char;
        push_tok.weight    = ilp_pkg::char_weight(chars.char_code);
        push_tok.take      = 1'b0;
        push_tok.lone_zero = 1'b0;
        push_tok.radix     = radix_reg;
        unique case (phase_reg)
            ilp_pkg::PH_IDLE:
            begin
                push_tok.radix     = ilp_pkg::RX_DEC;
                push_tok.take      = !is_us && !is_zero;
                push_tok.lone_zero = is_zero;
            end
            ilp_pkg::PH_ZERO:
            begin
                push_tok.radix     = ilp_pkg::RX_OCT;
                push_tok.take      = !is_us && !is_pfx;
                push_tok.lone_zero = is_us;
            end
            default:
            begin
                push_tok.take = !is_us;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ilp_pkg::PH_IDLE;
            radix_reg <= ilp_pkg::RX_DEC;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
        end
    end

endmodule

@@ hdl/ilp_queue.sv @@
// ----------------------------------------------------------------------------
// ilp_queue
// Small token queue between classifier and accumulator.
// ----------------------------------------------------------------------------
`include "integer_literal_parser_macros.svh"

module ilp_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ilp_pkg::token_t push_tok,
    output logic            push_ready,
    input  logic            pop,
    output ilp_pkg::token_t pop_tok,
    output logic            pop_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    ilp_pkg::token_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `ILP_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ILP_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !push, count_reg + 1'b1 == $past(count_reg))
    `ILP_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, pop, count_reg != '0)

endmodule

@@ hdl/ilp_back.sv @@
// ----------------------------------------------------------------------------
// ilp_back
// Digit accumulator with overflow detection and result register.
// ----------------------------------------------------------------------------
`include "integer_literal_parser_macros.svh"

module ilp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  ilp_pkg::token_t tok,
    input  logic            tok_valid,
    output logic            pop,
    ilp_result_if.source    results
);

    localparam int PROD_W = ilp_pkg::VALUE_W + 5;

    logic [ilp_pkg::VALUE_W-1:0] acc_reg;
    logic [ilp_pkg::VALUE_W-1:0] acc_next;
    logic                        seen_reg;
    logic                        seen_next;
    logic                        stopped_reg;
    logic                        stopped_next;
    logic                        ovf_reg;
    logic                        ovf_next;

    logic                        out_valid_reg;
    logic [ilp_pkg::VALUE_W-1:0] out_value_reg;
    ilp_pkg::status_t            out_status_reg;
    logic [ilp_pkg::VALUE_W-1:0] out_value_next;
    ilp_pkg::status_t            out_status_next;

    logic [PROD_W-1:0] acc_wide;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;
    logic              digit_ok;
    logic              sum_ovf;
    logic              load;

    assign acc_wide = PROD_W'(acc_reg);

    always_comb
    begin
        unique case (tok.radix)
            ilp_pkg::RX_BIN: prod = acc_wide << 1;
            ilp_pkg::RX_OCT: prod = acc_wide << 3;
            ilp_pkg::RX_HEX: prod = acc_wide << 4;
            default:         prod = (acc_wide << 3) + (acc_wide << 1);
        endcase
    end

    assign sum      = prod + PROD_W'(tok.weight);
    assign sum_ovf  = |sum[PROD_W-1:ilp_pkg::VALUE_W];
    assign digit_ok = ({1'b0, ilp_pkg::radix_base(tok.radix)} > tok.weight);

    // step
    always_comb
    begin
        acc_next     = acc_reg;
        seen_next    = seen_reg;
        stopped_next = stopped_reg;
        ovf_next     = ovf_reg;
        if (tok.take && !stopped_reg)
        begin
            if (!digit_ok)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                seen_next = 1'b1;
                if (!ovf_reg)
                begin
                    if (sum_ovf)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = sum[ilp_pkg::VALUE_W-1:0];
                    end
                end
            end
        end
    end

    // result
    always_comb
    begin
        if (tok.lone_zero)
        begin
            out_value_next  = '0;
            out_status_next = ilp_pkg::ST_OK;
        end
        else if (!seen_next)
        begin
            out_value_next  = '0;
            out_status_next = ilp_pkg::ST_NO_DIGITS;
        end
        else if (ovf_next)
        begin
            out_value_next  = ilp_pkg::VALUE_MAX;
            out_status_next = ilp_pkg::ST_OVERFLOW;
        end
        else
        begin
            out_value_next  = acc_next;
            out_status_next = ilp_pkg::ST_OK;
        end
    end

    assign pop  = tok_valid && !(tok.last && out_valid_reg && !results.ready);
    assign load = pop && tok.last;

    assign results.valid         = out_valid_reg;
    assign results.literal_value = out_value_reg;
    assign results.status        = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            stopped_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                acc_reg     <= '0;
                seen_reg    <= 1'b0;
                stopped_reg <= 1'b0;
                ovf_reg     <= 1'b0;
            end
            else if (pop)
            begin
                acc_reg     <= acc_next;
                seen_reg    <= seen_next;
                stopped_reg <= stopped_next;
                ovf_reg     <= ovf_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    `ILP_ASSERT_NEXT(a_stop_hold, clk, rst_n, stopped_reg && pop && !tok.last, acc_reg == $past(acc_reg))
    `ILP_ASSERT_IMPLY(a_ovf_seen, clk, rst_n, ovf_reg, seen_reg)
    `ILP_ASSERT_IMPLY(a_ovf_sat, clk, rst_n, out_valid_reg && out_status_reg == ilp_pkg::ST_OVERFLOW, out_value_reg == ilp_pkg::VALUE_MAX)

endmodule
